>>> hw/rtl/rgbed_pkg.sv
package rgbed_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W   = 32;
  localparam int CFG_W   = 11;
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 17;
  localparam int VAL_W   = 10;
  localparam int ERR_W   = 8;
  localparam int ERR_Q_W = 6;
  localparam int ERR_H_W = 7;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(640);

  localparam logic [SUM_W-1:0] COEF_R     = SUM_W'(153);
  localparam logic [SUM_W-1:0] COEF_G     = SUM_W'(301);
  localparam logic [SUM_W-1:0] COEF_B     = SUM_W'(58);
  localparam int               GRAY_SHIFT = 9;

  localparam logic [CHAN_W-1:0]       LEVEL_WHITE = 8'hF0;
  localparam logic [CHAN_W-1:0]       LEVEL_BLACK = 8'h00;
  localparam logic signed [VAL_W-1:0] VAL_HIGH    = 10'sh0F0;
  localparam logic signed [VAL_W-1:0] VAL_LOW     = 10'sh010;
  localparam int                      MSB_BIT     = 7;

  typedef struct packed {
    logic use_cur;
    logic use_next;
    logic use_left;
  } err_sel_t;

  function automatic logic [CHAN_W-1:0] gray_of(input logic [PIX_W-1:0] px);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(px[23:16]) * COEF_R
        + SUM_W'(px[15:8])  * COEF_G
        + SUM_W'(px[7:0])   * COEF_B;
    return sum[SUM_W-1:GRAY_SHIFT];
  endfunction

endpackage

>>> hw/rtl/rgbed_if.sv
interface rgbed_in_if;
  logic                          valid;
  logic                          ready;
  logic [rgbed_pkg::PIX_W-1:0]   pixel;
  logic                          frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface rgbed_out_if;
  logic                          valid;
  logic                          ready;
  logic [rgbed_pkg::PIX_W-1:0]   out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

>>> hw/rtl/rgbed_err_ram.sv
module rgbed_err_ram #(
  parameter int DEPTH = rgbed_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(rgbed_pkg::MAX_WIDTH_DEF)
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         wa,
  input  logic signed [rgbed_pkg::ERR_Q_W-1:0]  wd,
  input  logic                                  re,
  input  logic [AW-1:0]                         ra0,
  input  logic [AW-1:0]                         ra1,
  output logic signed [rgbed_pkg::ERR_Q_W-1:0]  rd0,
  output logic signed [rgbed_pkg::ERR_Q_W-1:0]  rd1
);

  logic signed [rgbed_pkg::ERR_Q_W-1:0] mem [DEPTH];
  logic signed [rgbed_pkg::ERR_Q_W-1:0] rd0_r;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] rd1_r;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] wd_r;
  logic                                 byp0_r;
  logic                                 byp1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0_r  <= mem[ra0];
      rd1_r  <= mem[ra1];
      byp0_r <= we && (wa == ra0);
      byp1_r <= we && (wa == ra1);
      wd_r   <= wd;
    end
  end

  // forward a write that lands on the same edge as the read
  assign rd0 = byp0_r ? wd_r : rd0_r;
  assign rd1 = byp1_r ? wd_r : rd1_r;

endmodule

>>> hw/rtl/rgbed_front.sv
module rgbed_front #(
  parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DEF,
  parameter int CW        = $clog2(rgbed_pkg::MAX_WIDTH_DEF)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [rgbed_pkg::PIX_W-1:0]        in_pixel,
  input  logic                               in_frame_start,
  output logic                               in_ready,
  input  logic                               cfg_we,
  input  logic [rgbed_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                               s1_adv,
  output logic                               s1_valid,
  output logic [rgbed_pkg::CHAN_W-1:0]       s1_gray,
  output logic [rgbed_pkg::CHAN_W-1:0]       s1_alpha,
  output logic [CW-1:0]                      s1_col,
  output rgbed_pkg::err_sel_t                s1_sel,
  output logic                               ram_re,
  output logic [CW-1:0]                      ram_ra0,
  output logic [CW-1:0]                      ram_ra1
);

  localparam int WW = CW + 1;

  logic [rgbed_pkg::CFG_W-1:0]  line_width_r;
  logic [CW-1:0]                col_r;
  logic [CW-1:0]                col_nxt;
  logic                         first_row_r;
  logic                         first_row_nxt;
  logic                         s1_valid_r;
  logic [rgbed_pkg::CHAN_W-1:0] s1_gray_r;
  logic [rgbed_pkg::CHAN_W-1:0] s1_alpha_r;
  logic [CW-1:0]                s1_col_r;
  rgbed_pkg::err_sel_t          s1_sel_r;
  rgbed_pkg::err_sel_t          sel_nxt;

  logic          accept;
  logic          over;
  logic [WW-1:0] w_eff;
  logic [CW-1:0] col_cur;
  logic          first_cur;
  logic [WW-1:0] col_plus;
  logic          last;

  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    over = 32'(line_width_r) > 32'(MAX_WIDTH);
    if (line_width_r == '0) begin
      w_eff = WW'(1);
    end else if (over) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width_r);
    end

    col_cur   = in_frame_start ? '0 : col_r;
    first_cur = in_frame_start || first_row_r;
    col_plus  = {1'b0, col_cur} + WW'(1);
    last      = col_plus >= w_eff;

    col_nxt       = last ? '0 : col_plus[CW-1:0];
    first_row_nxt = last ? 1'b0 : first_cur;

    sel_nxt.use_cur  = !first_cur;
    sel_nxt.use_next = !first_cur && !last;
    sel_nxt.use_left = !first_cur && (col_cur != '0);
  end

  assign ram_re  = accept;
  assign ram_ra0 = col_cur;
  assign ram_ra1 = last ? '0 : col_plus[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= rgbed_pkg::LINE_WIDTH_RST;
      col_r        <= '0;
      first_row_r  <= 1'b1;
      s1_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_width_r <= cfg_wdata;
      end
      if (accept) begin
        col_r       <= col_nxt;
        first_row_r <= first_row_nxt;
        s1_valid_r  <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray_r  <= rgbed_pkg::gray_of(in_pixel);
      s1_alpha_r <= in_pixel[31:24];
      s1_col_r   <= col_cur;
      s1_sel_r   <= sel_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_gray  = s1_gray_r;
  assign s1_alpha = s1_alpha_r;
  assign s1_col   = s1_col_r;
  assign s1_sel   = s1_sel_r;

  a_frame_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_frame_start |=> s1_col_r == '0 && s1_sel_r == '0)
    else $error("frame start pixel picked up error terms");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_gray_r))
    else $error("stalled pixel changed");

  a_left_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_sel_r.use_left |-> s1_sel_r.use_cur && s1_col_r != '0)
    else $error("left term outside a later row");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> col_r == '0 && !first_row_r)
    else $error("row end did not wrap column");

endmodule

>>> hw/rtl/rgbed_back.sv
module rgbed_back #(
  parameter int CW = $clog2(rgbed_pkg::MAX_WIDTH_DEF)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  s1_valid,
  input  logic [rgbed_pkg::CHAN_W-1:0]          s1_gray,
  input  logic [rgbed_pkg::CHAN_W-1:0]          s1_alpha,
  input  logic [CW-1:0]                         s1_col,
  input  rgbed_pkg::err_sel_t                   s1_sel,
  input  logic signed [rgbed_pkg::ERR_Q_W-1:0]  rd0,
  input  logic signed [rgbed_pkg::ERR_Q_W-1:0]  rd1,
  output logic                                  s1_adv,
  output logic                                  ram_we,
  output logic [CW-1:0]                         ram_wa,
  output logic signed [rgbed_pkg::ERR_Q_W-1:0]  ram_wd,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rgbed_pkg::PIX_W-1:0]           out_pixel
);

  logic signed [rgbed_pkg::ERR_H_W-1:0] left_r;
  logic signed [rgbed_pkg::ERR_H_W-1:0] left_nxt;
  logic                                 out_valid_r;
  logic [rgbed_pkg::PIX_W-1:0]          out_pixel_r;

  logic signed [rgbed_pkg::VAL_W-1:0] val;
  logic signed [rgbed_pkg::VAL_W-1:0] diff;
  logic signed [rgbed_pkg::ERR_W-1:0] err;
  logic [rgbed_pkg::CHAN_W-1:0]       q;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] quarter;

  always_comb begin
    val = $signed({2'b00, s1_gray});
    if (s1_sel.use_cur) begin
      val = val + rgbed_pkg::VAL_W'(rd0);
    end
    if (s1_sel.use_next) begin
      val = val + rgbed_pkg::VAL_W'(rd1);
    end
    if (s1_sel.use_left) begin
      val = val + rgbed_pkg::VAL_W'(left_r);
    end

    q    = rgbed_pkg::LEVEL_BLACK;
    diff = '0;
    if (val >= rgbed_pkg::VAL_HIGH) begin
      q = rgbed_pkg::LEVEL_WHITE;
    end else if (val > rgbed_pkg::VAL_LOW) begin
      q    = val[rgbed_pkg::MSB_BIT] ? rgbed_pkg::LEVEL_WHITE : rgbed_pkg::LEVEL_BLACK;
      diff = val - $signed({2'b00, q});
    end
    err      = diff[rgbed_pkg::ERR_W-1:0];
    quarter  = rgbed_pkg::ERR_Q_W'(err >>> 2);
    left_nxt = rgbed_pkg::ERR_H_W'(err >>> 1);
  end

  assign s1_adv = !out_valid_r || out_ready;
  assign ram_we = s1_valid && s1_adv;
  assign ram_wa = s1_col;
  assign ram_wd = quarter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if (s1_valid && s1_adv) begin
        out_valid_r <= 1'b1;
        left_r      <= left_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_pixel_r <= {s1_alpha, q, q, q};
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

>>> hw/rtl/rgb_error_diffusion_bw_dither_unit.sv
// Black-and-white error diffusion dither for a raster stream of 32-bit pixels
// (blue in byte 0, green in byte 1, red in byte 2, alpha in byte 3). Each pixel
// is reduced to gray, corrected by the diffused error of its left neighbor and
// of two neighbors in the row above, and returned with R=G=B set to 0 or 240
// and alpha untouched. The block takes one pixel every clock while the output
// is not stalled. The edge that accepts a beat loads the input register and,
// in parallel, the registered read of the row error RAM (two read ports, one
// write port, MAX_WIDTH entries); the quantizer's output register is loaded
// from them when the output can advance, and a stalled output holds both
// stages and the input. Assert frame_start on the first pixel of every
// image; line_width may be written only while no pixel is in flight, and a
// width at or below the current column ends the row at that pixel. The RAM
// needs no clearing after reset.
module rgb_error_diffusion_bw_dither_unit #(
  parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rgbed_in_if.sink                    in_chan,
  rgbed_out_if.source                 out_chan,
  input  logic                        cfg_we,
  input  logic [rgbed_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                                 s1_valid;
  logic [rgbed_pkg::CHAN_W-1:0]         s1_gray;
  logic [rgbed_pkg::CHAN_W-1:0]         s1_alpha;
  logic [CW-1:0]                        s1_col;
  rgbed_pkg::err_sel_t                  s1_sel;
  logic                                 s1_adv;
  logic                                 ram_re;
  logic [CW-1:0]                        ram_ra0;
  logic [CW-1:0]                        ram_ra1;
  logic                                 ram_we;
  logic [CW-1:0]                        ram_wa;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] ram_wd;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] rd0;
  logic signed [rgbed_pkg::ERR_Q_W-1:0] rd1;

  rgbed_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_pixel       (in_chan.pixel),
    .in_frame_start (in_chan.frame_start),
    .in_ready       (in_chan.ready),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s1_adv         (s1_adv),
    .s1_valid       (s1_valid),
    .s1_gray        (s1_gray),
    .s1_alpha       (s1_alpha),
    .s1_col         (s1_col),
    .s1_sel         (s1_sel),
    .ram_re         (ram_re),
    .ram_ra0        (ram_ra0),
    .ram_ra1        (ram_ra1)
  );

  rgbed_err_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_err_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra0 (ram_ra0),
    .ra1 (ram_ra1),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  rgbed_back #(
    .CW (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_gray   (s1_gray),
    .s1_alpha  (s1_alpha),
    .s1_col    (s1_col),
    .s1_sel    (s1_sel),
    .rd0       (rd0),
    .rd1       (rd1),
    .s1_adv    (s1_adv),
    .ram_we    (ram_we),
    .ram_wa    (ram_wa),
    .ram_wd    (ram_wd),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pixel (out_chan.out_pixel)
  );

endmodule

>>> test/rgbed_dither_checker.sv
module rgbed_dither_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  rgbed_in_if                         in_mon,
  rgbed_out_if                        out_mon,
  input  logic                        cfg_we,
  input  logic [rgbed_pkg::CFG_W-1:0] cfg_wdata,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rgbed_pkg::*;

  logic [CFG_W-1:0]          width_q;
  logic signed [ERR_Q_W-1:0] upper_q [MAX_WIDTH_DEF];
  logic signed [ERR_H_W-1:0] left_half_q;
  int unsigned               col_q;
  bit                        row0_q;
  logic [PIX_W-1:0]          dithered_q [$];

  function automatic logic [PIX_W-1:0] dither_pixel(input logic [PIX_W-1:0] px,
                                                    input logic fs);
    int unsigned      w;
    int unsigned      col;
    int               lvl;
    int               err;
    logic [CHAN_W-1:0] q;
    if (width_q == 0) begin
      w = 1;
    end else if (width_q > MAX_WIDTH_DEF) begin
      w = MAX_WIDTH_DEF;
    end else begin
      w = width_q;
    end
    if (fs) begin
      col_q = 0;
      row0_q = 1'b1;
      left_half_q = '0;
    end
    col = col_q;
    lvl = (int'(px[23:16]) * 153 + int'(px[15:8]) * 301 + int'(px[7:0]) * 58) >>> 9;
    if (!row0_q) begin
      if (col < MAX_WIDTH_DEF) lvl += int'(upper_q[col]);
      if (col + 1 < w && col + 1 < MAX_WIDTH_DEF) lvl += int'(upper_q[col + 1]);
      if (col != 0) lvl += int'(left_half_q);
    end
    if (lvl >= int'(VAL_HIGH)) begin
      q = LEVEL_WHITE;
      err = 0;
    end else if (lvl <= int'(VAL_LOW)) begin
      q = LEVEL_BLACK;
      err = 0;
    end else begin
      q = lvl[MSB_BIT] ? LEVEL_WHITE : LEVEL_BLACK;
      err = lvl - int'(q);
    end
    if (col < MAX_WIDTH_DEF) upper_q[col] = ERR_Q_W'(err >>> 2);
    left_half_q = ERR_H_W'(err >>> 1);
    if (col + 1 >= w) begin
      col_q = 0;
      row0_q = 1'b0;
    end else begin
      col_q = col + 1;
    end
    return {px[31:24], q, q, q};
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      width_q = LINE_WIDTH_RST;
      left_half_q = '0;
      col_q = 0;
      row0_q = 1'b1;
      dithered_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (dithered_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected output beat %08h at %0t", out_mon.out_pixel, $realtime);
          end
          mismatches++;
        end else begin
          want = dithered_q.pop_front();
          if (out_mon.out_pixel !== want) begin
            if (mismatches < 10) begin
              $display("out_pixel mismatch at %0t: expected %08h, got %08h",
                       $realtime, want, out_mon.out_pixel);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        dithered_q.push_back(dither_pixel(in_mon.pixel, in_mon.frame_start));
      end
      if (cfg_we) width_q = cfg_wdata;
    end
    pending = dithered_q.size();
  end

endmodule

>>> test/rgb_error_diffusion_bw_dither_unit_test.sv
module rgb_error_diffusion_bw_dither_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_COUNT  = 450;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [rgbed_pkg::CFG_W-1:0] cfg_wdata;
  int                          mismatch_count;
  int                          pending_count;
  int                          cycles;
  int                          sent_total;
  bit                          tx_steady;
  int unsigned                 eff_w;
  int unsigned                 col_pos;

  rgbed_in_if  in_if ();
  rgbed_out_if out_if ();

  rgb_error_diffusion_bw_dither_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rgbed_dither_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatch_count),
    .pending    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rgb_error_diffusion_bw_dither_unit");
      $finish;
    end
  end

  task automatic send_pixel(input logic [rgbed_pkg::PIX_W-1:0] px, input logic fs);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.pixel = px;
    in_if.frame_start = fs;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    sent_total++;
    if (fs) col_pos = 0;
    col_pos++;
    if (col_pos >= eff_w) col_pos = 0;
  endtask

  task automatic write_width(input logic [rgbed_pkg::CFG_W-1:0] v);
    in_if.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (v == 0) begin
      eff_w = 1;
    end else if (v > rgbed_pkg::MAX_WIDTH_DEF) begin
      eff_w = rgbed_pkg::MAX_WIDTH_DEF;
    end else begin
      eff_w = v;
    end
  endtask

  function automatic logic [rgbed_pkg::PIX_W-1:0] pick_pixel();
    logic [rgbed_pkg::CHAN_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: v = rgbed_pkg::CHAN_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 8))
          0: v = 8'd15;
          1: v = 8'd16;
          2: v = 8'd17;
          3: v = 8'd126;
          4: v = 8'd127;
          5: v = 8'd128;
          6: v = 8'd129;
          7: v = 8'd239;
          default: v = 8'd240;
        endcase
      end
    endcase
    return {8'($urandom), v, v, v};
  endfunction

  // output side: random hold-offs per beat, one long stall to back up the input
  initial begin
    int  wait_n;
    int  beats;
    bit  steady;
    out_if.ready = 1'b0;
    beats = 0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (beats == 120) begin
        wait_n = 400;
      end else begin
        wait_n = steady ? 0 : $urandom_range(0, 13);
      end
      if (wait_n > 0) begin
        out_if.ready = 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
      beats++;
    end
  end

  initial begin
    int                          n;
    int                          half;
    int                          k;
    logic [rgbed_pkg::CFG_W-1:0] w_new;
    in_if.valid = 1'b0;
    in_if.pixel = '0;
    in_if.frame_start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    tx_steady = 1'b0;
    sent_total = 0;
    eff_w = rgbed_pkg::LINE_WIDTH_RST;
    col_pos = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hA580_8080, 1'b0);
    // shrink to the current column inside the first row
    write_width(11'd3);
    send_pixel(32'h5A7F_7F7F, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFF10_1010, 1'b0);
    send_pixel(32'h1211_1111, 1'b0);
    send_pixel(32'h34EF_EFEF, 1'b0);
    send_pixel(32'h56F0_F0F0, 1'b0);
    send_pixel(32'h7881_8181, 1'b0);
    send_pixel(32'h9A80_8080, 1'b0);
    send_pixel(32'hBC7F_7F7F, 1'b1);
    send_pixel(32'hDE40_4040, 1'b0);
    send_pixel(32'hEF00_00FF, 1'b0);
    send_pixel(32'h0100_FF00, 1'b0);
    write_width(11'd0);
    send_pixel(32'h8090_9090, 1'b1);
    send_pixel(32'h4060_6060, 1'b0);
    send_pixel(32'h20A0_A0A0, 1'b0);
    send_pixel(32'h10FF_0000, 1'b0);

    while (sent_total < ITEM_COUNT) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        w_new = $urandom_range(1, 8);
      end else if (k == 7) begin
        w_new = '0;
      end else begin
        w_new = $urandom_range(9, 40);
      end
      write_width(w_new);
      tx_steady = ($urandom_range(0, 3) == 0);
      n = eff_w * $urandom_range(2, 5) + $urandom_range(0, eff_w);
      if (n > ITEM_COUNT - sent_total) n = ITEM_COUNT - sent_total;
      half = ($urandom_range(0, 2) == 0) ? n / 2 : -1;
      for (int i = 0; i < n; i++) begin
        if (i == half && col_pos != 0) begin
          write_width(rgbed_pkg::CFG_W'($urandom_range(0, col_pos)));
        end
        send_pixel(pick_pixel(), i == 0 || $urandom_range(0, 49) == 0);
      end
    end

    in_if.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rgb_error_diffusion_bw_dither_unit");
    end else begin
      $display("FAIL rgb_error_diffusion_bw_dither_unit");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rgbed_pkg.sv
hw/rtl/rgbed_if.sv
hw/rtl/rgbed_err_ram.sv
hw/rtl/rgbed_front.sv
hw/rtl/rgbed_back.sv
hw/rtl/rgb_error_diffusion_bw_dither_unit.sv
test/rgbed_dither_checker.sv
test/rgb_error_diffusion_bw_dither_unit_test.sv
